@@ sv/hsk_pkg.sv @@
// Shared types, codes and helpers for the Hermite spline knot table.
// No dependencies; every other file in sv/ imports this package.
package hsk_pkg;

  localparam int KNOTS_DEF = 64;
  localparam int FRAC_DEF  = 16;
  localparam int VAL_W     = 32;
  localparam int COEF_W    = 48;
  // cell index / count field, wide enough for the largest table
  localparam int POS_W     = 11;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_EVAL   = 1'b1;

  localparam logic [2:0] STAT_EVAL  = 3'd0;
  localparam logic [2:0] STAT_RANGE = 3'd1;
  localparam logic [2:0] STAT_INS   = 3'd2;
  localparam logic [2:0] STAT_DUP   = 3'd3;
  localparam logic [2:0] STAT_FULL  = 3'd4;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_ROT,
    CMD_INS,
    CMD_WRC
  } cell_cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  x;
    logic signed [VAL_W-1:0]  y;
    logic signed [VAL_W-1:0]  slope;
    logic signed [COEF_W-1:0] quad;
    logic signed [COEF_W-1:0] cubic;
  } knot_t;

  typedef struct packed {
    cell_cmd_t                cmd;
    logic [POS_W-1:0]         pos;
    logic [POS_W-1:0]         count;
    knot_t                    fresh;
    logic signed [COEF_W-1:0] wq;
    logic signed [COEF_W-1:0] wc;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHK,
    ST_INS,
    ST_PREP,
    ST_MUL,
    ST_NUM,
    ST_QGO,
    ST_QDIV,
    ST_CDIV1,
    ST_CDIV2,
    ST_WR,
    ST_EVAL,
    ST_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    HP_IDLE,
    HP_MUL,
    HP_ADD,
    HP_SAT
  } hp_state_t;

  // clamp to signed 48 bits, or to signed 32 bits (sign-extended) when to32
  function automatic logic signed [COEF_W-1:0] sat_fix(input logic signed [127:0] v,
                                                       input logic to32);
    logic signed [127:0]       hi;
    logic signed [127:0]       lo;
    logic signed [COEF_W-1:0]  r;
    hi = to32 ? 128'sd2147483647 : 128'sd140737488355327;
    lo = -hi - 128'sd1;
    if (v > hi) begin
      r = hi[COEF_W-1:0];
    end else if (v < lo) begin
      r = lo[COEF_W-1:0];
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/hsk_cell.sv @@
// One knot cell of the ring: holds x, y, slope and segment coefficients.
// Depends on hsk_pkg.
module hsk_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  hsk_pkg::cell_ctrl_t ctrl,
  input  hsk_pkg::knot_t     from_prev,
  input  hsk_pkg::knot_t     from_next,
  output hsk_pkg::knot_t     knot
);
  import hsk_pkg::*;

  localparam logic [POS_W-1:0] ME = POS_W'(IDX);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_ROT: begin
        knot <= from_next;
      end
      CMD_INS: begin
        // cells at and above the slot move up by one
        if (ME == ctrl.pos) begin
          knot <= ctrl.fresh;
        end else if (ME > ctrl.pos && ME <= ctrl.count) begin
          knot <= from_prev;
        end
      end
      CMD_WRC: begin
        if (ME == ctrl.pos) begin
          knot.quad  <= ctrl.wq;
          knot.cubic <= ctrl.wc;
        end
      end
      default: begin
        knot <= knot;
      end
    endcase
  end

endmodule

@@ sv/hsk_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, with a final
// sign and 48-bit clamp step. Depends on hsk_pkg.
module hsk_div #(
  parameter int NW = 100
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [NW-1:0]                     mag,
  input  logic                              neg,
  input  logic [63:0]                       den,
  output logic [NW-1:0]                     q,
  output logic signed [hsk_pkg::COEF_W-1:0] qsat,
  output logic                              done
);
  import hsk_pkg::*;

  localparam int CNT_W = $clog2(NW + 1);

  logic [63:0]      rem;
  logic [NW-1:0]    quo;
  logic             sign_r;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             fin;
  logic [64:0]      rem_sh;
  logic [64:0]      rem_sub;
  logic             fit;

  assign rem_sh  = {rem, quo[NW-1]};
  assign fit     = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};
  assign q       = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        run    <= 1'b1;
        fin    <= 1'b0;
        done   <= 1'b0;
        cnt    <= '0;
        quo    <= mag;
        rem    <= '0;
        sign_r <= neg;
      end else if (run) begin
        done <= 1'b0;
        // dividend bits leave the top of quo, quotient bits enter the bottom
        quo <= {quo[NW-2:0], fit};
        rem <= fit ? rem_sub[63:0] : rem_sh[63:0];
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NW - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        qsat <= sat_fix(sign_r ? -128'(quo) : 128'(quo), 1'b0);
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

@@ sv/hsk_horner.sv @@
// Horner evaluator: six multiply-shift-add-clamp steps on one shared
// split multiplier, each through the MUL, ADD and SAT states. Depends on hsk_pkg.
module hsk_horner #(
  parameter int FRAC_BITS = hsk_pkg::FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [32:0]                t,
  input  logic signed [hsk_pkg::COEF_W-1:0] c2,
  input  logic signed [hsk_pkg::COEF_W-1:0] c3,
  input  logic signed [hsk_pkg::VAL_W-1:0]  d,
  input  logic signed [hsk_pkg::VAL_W-1:0]  y,
  output logic signed [hsk_pkg::VAL_W-1:0]  val,
  output logic signed [hsk_pkg::VAL_W-1:0]  slp,
  output logic signed [hsk_pkg::VAL_W-1:0]  crv,
  output logic                              done
);
  import hsk_pkg::*;

  localparam int AW = 52;
  localparam int LW = 26;
  localparam int PW = 86;

  localparam logic [2:0] OP_H1  = 3'd0;
  localparam logic [2:0] OP_H2  = 3'd1;
  localparam logic [2:0] OP_VAL = 3'd2;
  localparam logic [2:0] OP_H3  = 3'd3;
  localparam logic [2:0] OP_SLP = 3'd4;
  localparam logic [2:0] OP_CRV = 3'd5;

  hp_state_t state, state_next;

  logic [2:0]               op;
  logic signed [COEF_W-1:0] h;
  logic signed [AW-1:0]     c3x3;
  logic signed [AW-1:0]     c2x2;
  logic signed [AW-1:0]     a;
  logic signed [AW-1:0]     base;
  logic signed [AW-1:0]     base_r;
  logic signed [59:0]       pl;
  logic signed [58:0]       ph;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     sum_r;
  logic                     to32;
  logic signed [COEF_W-1:0] r;

  always_comb begin
    case (op)
      OP_H1: begin
        a    = AW'(c3);
        base = AW'(c2);
      end
      OP_H2, OP_SLP: begin
        a    = AW'(h);
        base = AW'(d);
      end
      OP_VAL: begin
        a    = AW'(h);
        base = AW'(y);
      end
      OP_H3: begin
        a    = c3x3;
        base = c2x2;
      end
      default: begin
        a    = c3x3 <<< 1;
        base = c2x2;
      end
    endcase
  end

  assign to32 = (op == OP_VAL) || (op == OP_SLP) || (op == OP_CRV);
  assign prod = (PW'(ph) <<< LW) + PW'(pl);
  assign r    = sat_fix(128'(sum_r), to32);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      HP_IDLE: begin
        if (start) begin
          state_next = HP_MUL;
        end
      end
      HP_MUL: begin
        state_next = HP_ADD;
      end
      HP_ADD: begin
        state_next = HP_SAT;
      end
      HP_SAT: begin
        state_next = (op == OP_CRV) ? HP_IDLE : HP_MUL;
      end
      default: begin
        state_next = HP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      op   <= OP_H1;
    end else begin
      done <= (state == HP_SAT) && (op == OP_CRV);
      case (state)
        HP_IDLE: begin
          if (start) begin
            op   <= OP_H1;
            c3x3 <= AW'(c3) + (AW'(c3) <<< 1);
            c2x2 <= AW'(c2) <<< 1;
          end
        end
        HP_MUL: begin
          pl     <= $signed({1'b0, a[LW-1:0]}) * t;
          ph     <= $signed(a[AW-1:LW]) * t;
          base_r <= base;
        end
        HP_ADD: begin
          // floor(a*t / 2^F) then add the base term
          sum_r <= (prod >>> FRAC_BITS) + PW'(base_r);
        end
        HP_SAT: begin
          case (op)
            OP_VAL:  val <= r[VAL_W-1:0];
            OP_SLP:  slp <= r[VAL_W-1:0];
            OP_CRV:  crv <= r[VAL_W-1:0];
            default: h   <= r;
          endcase
          if (op != OP_CRV) begin
            op <= op + 3'd1;
          end
        end
        default: begin
          op <= OP_H1;
        end
      endcase
    end
  end

endmodule

@@ sv/hermite_spline_knot_table.sv @@
// Hermite spline knot table: top level with the ring of knot cells, scan and
// refit sequencer. Depends on hsk_pkg, hsk_cell, hsk_div, hsk_horner.
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   in      | in_valid in_stall func pos_x knot_y      | in
//           | knot_slope                               |
//   out     | out_valid out_stall value slope          | out
//           | curvature status                         |
//
// One item at a time. Every item rotates the knot ring once. Evaluate: after the
// scan, Horner runs six steps; a point out of range, a duplicate or a full table
// goes straight to the result. Insert: each refit segment (up to two) runs the
// PREP, MUL and NUM states and three bit-serial divisions.
// The result beat sits in an output register; a stalled output holds the
// block after the current item only. Reset empties the table.
module hermite_spline_knot_table #(
  parameter int MAX_KNOTS = hsk_pkg::KNOTS_DEF,
  parameter int FRAC_BITS = hsk_pkg::FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic signed [hsk_pkg::VAL_W-1:0] pos_x,
  input  logic signed [hsk_pkg::VAL_W-1:0] knot_y,
  input  logic signed [hsk_pkg::VAL_W-1:0] knot_slope,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [hsk_pkg::VAL_W-1:0] value,
  output logic signed [hsk_pkg::VAL_W-1:0] slope,
  output logic signed [hsk_pkg::VAL_W-1:0] curvature,
  output logic [2:0]                       status
);
  import hsk_pkg::*;

  localparam int IW   = $clog2(MAX_KNOTS);
  localparam int CNTW = $clog2(MAX_KNOTS + 1);
  localparam int EW   = CNTW + 1;
  localparam int NW   = 68 + 2 * FRAC_BITS;
  localparam logic [IW-1:0] LAST = IW'(MAX_KNOTS - 1);

  top_state_t state, state_next;

  knot_t knots [MAX_KNOTS];
  knot_t c0, c1, new_k, seg_a, seg_b;
  knot_t prev_k, next_k, seg_k;

  logic [IW-1:0]            step;
  logic [CNTW-1:0]          count;
  logic [CNTW-1:0]          p;
  logic                     func_r;
  logic signed [VAL_W-1:0]  xr, yr, sr;
  logic                     dup, have_prev, have_next, hit, seg_low;
  logic                     in0, in1, full;
  logic signed [32:0]       tt, dx, dy, s1;
  logic signed [33:0]       s2;
  logic signed [66:0]       pq;
  logic signed [65:0]       pc;
  logic [63:0]              den2;
  logic signed [NW-1:0]     qn, cn, qs, cs, dyw;
  logic signed [COEF_W-1:0] quad_r, cubic_r;
  logic [2:0]               status_r;
  cell_ctrl_t               ctrl;

  logic                     div_start, div_neg, div_done;
  logic [NW-1:0]            div_mag, div_q;
  logic [63:0]              div_den;
  logic signed [COEF_W-1:0] div_qsat;

  logic                     hz_start, hz_done;
  logic signed [VAL_W-1:0]  hz_val, hz_slp, hz_crv;

  // ring of knot cells; at scan step s cell 0 holds knot s
  for (genvar i = 0; i < MAX_KNOTS; i++) begin : g_cell
    hsk_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .from_prev(knots[(i + MAX_KNOTS - 1) % MAX_KNOTS]),
      .from_next(knots[(i + 1) % MAX_KNOTS]),
      .knot     (knots[i])
    );
  end

  hsk_div #(
    .NW(NW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .mag  (div_mag),
    .neg  (div_neg),
    .den  (div_den),
    .q    (div_q),
    .qsat (div_qsat),
    .done (div_done)
  );

  hsk_horner #(
    .FRAC_BITS(FRAC_BITS)
  ) u_horner (
    .clk  (clk),
    .rst  (rst),
    .start(hz_start),
    .t    (tt),
    .c2   (seg_k.quad),
    .c3   (seg_k.cubic),
    .d    (seg_k.slope),
    .y    (seg_k.y),
    .val  (hz_val),
    .slp  (hz_slp),
    .crv  (hz_crv),
    .done (hz_done)
  );

  assign c0       = knots[0];
  assign c1       = knots[1];
  assign in0      = EW'(step) < EW'(count);
  assign in1      = (EW'(step) + EW'(1)) < EW'(count);
  assign full     = count == CNTW'(MAX_KNOTS);
  assign new_k    = '{x: xr, y: yr, slope: sr, quad: '0, cubic: '0};
  assign seg_a    = seg_low ? prev_k : new_k;
  assign seg_b    = seg_low ? new_k : next_k;
  assign dyw      = NW'(dy);
  assign qs       = qn <<< FRAC_BITS;
  assign cs       = cn <<< (2 * FRAC_BITS);
  assign in_stall = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctrl.cmd    = CMD_HOLD;
    ctrl.pos    = POS_W'(p);
    ctrl.count  = POS_W'(count);
    ctrl.fresh  = new_k;
    ctrl.wq     = quad_r;
    ctrl.wc     = cubic_r;
    div_start   = 1'b0;
    div_neg     = qn[NW-1];
    div_mag     = qn[NW-1] ? NW'(-qs) : NW'(qs);
    div_den     = den2;
    hz_start    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl.cmd = CMD_ROT;
        if (step == LAST) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (func_r == FN_EVAL) begin
          hz_start   = hit;
          state_next = hit ? ST_EVAL : ST_DONE;
        end else begin
          state_next = (dup || full) ? ST_DONE : ST_INS;
        end
      end
      ST_INS: begin
        ctrl.cmd   = CMD_INS;
        state_next = (have_prev || have_next) ? ST_PREP : ST_DONE;
      end
      ST_PREP: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_NUM;
      end
      ST_NUM: begin
        state_next = ST_QGO;
      end
      ST_QGO: begin
        div_start  = 1'b1;
        state_next = ST_QDIV;
      end
      ST_QDIV: begin
        div_neg = cn[NW-1];
        div_mag = cn[NW-1] ? NW'(-cs) : NW'(cs);
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_CDIV1;
        end
      end
      ST_CDIV1: begin
        // second stage of the cubic divide: trunc(trunc(n/dx^2)/dx)
        div_neg = cn[NW-1];
        div_mag = div_q;
        div_den = {32'd0, dx[31:0]};
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_CDIV2;
        end
      end
      ST_CDIV2: begin
        if (div_done) begin
          state_next = ST_WR;
        end
      end
      ST_WR: begin
        ctrl.cmd   = CMD_WRC;
        ctrl.pos   = seg_low ? POS_W'(p) - POS_W'(1) : POS_W'(p);
        state_next = (seg_low && have_next) ? ST_PREP : ST_DONE;
      end
      ST_EVAL: begin
        if (hz_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      // in ST_DONE the output register is reloaded instead
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            func_r    <= func;
            xr        <= pos_x;
            yr        <= knot_y;
            sr        <= knot_slope;
            step      <= '0;
            p         <= '0;
            dup       <= 1'b0;
            hit       <= 1'b0;
            have_prev <= 1'b0;
            have_next <= 1'b0;
          end
        end
        ST_SCAN: begin
          step <= (step == LAST) ? '0 : step + IW'(1);
          if (func_r == FN_EVAL) begin
            if (in1 && c0.x <= xr && xr < c1.x) begin
              hit   <= 1'b1;
              seg_k <= c0;
              tt    <= 33'(xr) - 33'(c0.x);
            end
          end else if (in0) begin
            if (c0.x == xr) begin
              dup <= 1'b1;
            end
            // last knot below x wins: it is the predecessor of the slot
            if (c0.x < xr) begin
              p         <= CNTW'(step) + CNTW'(1);
              prev_k    <= c0;
              have_prev <= 1'b1;
              next_k    <= c1;
              have_next <= in1;
            end else if (step == '0) begin
              next_k    <= c0;
              have_next <= 1'b1;
            end
          end
        end
        ST_CHK: begin
          if (func_r == FN_EVAL) begin
            status_r <= hit ? STAT_EVAL : STAT_RANGE;
          end else if (dup) begin
            status_r <= STAT_DUP;
          end else if (full) begin
            status_r <= STAT_FULL;
          end else begin
            status_r <= STAT_INS;
          end
        end
        ST_INS: begin
          count   <= count + CNTW'(1);
          seg_low <= have_prev;
        end
        ST_PREP: begin
          dx <= 33'(seg_b.x) - 33'(seg_a.x);
          dy <= 33'(seg_b.y) - 33'(seg_a.y);
          s1 <= 33'(seg_a.slope) + 33'(seg_b.slope);
          s2 <= (34'(seg_a.slope) <<< 1) + 34'(seg_b.slope);
        end
        ST_MUL: begin
          pq   <= s2 * dx;
          pc   <= s1 * dx;
          den2 <= dx[31:0] * dx[31:0];
        end
        ST_NUM: begin
          qn <= ((dyw + (dyw <<< 1)) <<< FRAC_BITS) - NW'(pq);
          cn <= NW'(pc) - ((dyw <<< 1) <<< FRAC_BITS);
        end
        ST_QDIV: begin
          if (div_done) begin
            quad_r <= div_qsat;
          end
        end
        ST_CDIV2: begin
          if (div_done) begin
            cubic_r <= div_qsat;
          end
        end
        ST_WR: begin
          seg_low <= 1'b0;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= status_r;
            if (func_r == FN_EVAL && hit) begin
              value     <= hz_val;
              slope     <= hz_slp;
              curvature <= hz_crv;
            end else begin
              value     <= '0;
              slope     <= '0;
              curvature <= '0;
            end
          end
        end
        default: begin
          step <= step;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_KNOTS))
    else $error("knot count above table size");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_INS |=> count == $past(count) + CNTW'(1))
    else $error("insert did not bump knot count");

  a_ins_legal: assert property (@(posedge clk) disable iff (rst)
    state == ST_INS |-> !dup && !full && func_r == FN_INSERT)
    else $error("insert of duplicate or into full table");

  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && step == LAST |=> state == ST_CHK && step == '0)
    else $error("ring rotation did not close");
`endif

endmodule

@@ bench/hermite_spline_knot_table_tb.sv @@
// Testbench for hermite_spline_knot_table: random and directed inserts and evaluations,
// checked beat by beat against a scoreboard that keeps its own copy of the knot table.
// Depends on hsk_pkg and the RTL under sv/.
module hermite_spline_knot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsk_pkg::*;

  localparam int N_KNOTS = 64;
  localparam int N_RANDOM = 930;
  localparam int IDLE_LIMIT = 8000;
  localparam int HOLD_CYCLES = 2000;

  typedef struct {
    logic signed [31:0] val;
    logic signed [31:0] slp;
    logic signed [31:0] crv;
    logic [2:0]         st;
  } spline_result_t;

  class spline_scoreboard;
    logic signed [31:0] xs[N_KNOTS];
    logic signed [31:0] ys[N_KNOTS];
    logic signed [31:0] ds[N_KNOTS];
    logic signed [47:0] qc[N_KNOTS];
    logic signed [47:0] cc[N_KNOTS];
    int count;
    int errors;
    int checked;
    spline_result_t expected_q[$];

    function automatic logic signed [47:0] clamp(logic signed [127:0] v, int bits);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
      lo = -hi - 128'sd1;
      if (v > hi) v = hi;
      else if (v < lo) v = lo;
      return v[47:0];
    endfunction

    function automatic logic signed [127:0] fmul(logic signed [127:0] a,
                                                 logic signed [127:0] t);
      return (a * t) >>> FRAC_DEF;
    endfunction

    function void refit(int a);
      logic signed [127:0] dx, dy, da, db, num;
      if (a + 1 >= count) return;
      dx = xs[a+1];
      dx = dx - xs[a];
      dy = ys[a+1];
      dy = dy - ys[a];
      da = ds[a];
      db = ds[a+1];
      num = 3 * dy * 65536 - (2 * da + db) * dx;
      qc[a] = clamp((num <<< FRAC_DEF) / (dx * dx), 48);
      num = (da + db) * dx - 2 * dy * 65536;
      cc[a] = clamp((num <<< (2 * FRAC_DEF)) / (dx * dx * dx), 48);
    endfunction

    // works out the result of one accepted input beat and updates the table
    function void note_input(logic f, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] s);
      spline_result_t r;
      logic signed [127:0] t, c2, c3, d, h;
      int p;
      r.val = 0;
      r.slp = 0;
      r.crv = 0;
      if (f == FN_INSERT) begin
        p = 0;
        while (p < count && xs[p] < x) p++;
        if (p < count && xs[p] == x) begin
          r.st = STAT_DUP;
        end else if (count >= N_KNOTS) begin
          r.st = STAT_FULL;
        end else begin
          for (int i = count; i > p; i--) begin
            xs[i] = xs[i-1];
            ys[i] = ys[i-1];
            ds[i] = ds[i-1];
            qc[i] = qc[i-1];
            cc[i] = cc[i-1];
          end
          xs[p] = x;
          ys[p] = y;
          ds[p] = s;
          qc[p] = 0;
          cc[p] = 0;
          count++;
          refit(p);
          if (p > 0) refit(p - 1);
          r.st = STAT_INS;
        end
      end else begin
        r.st = STAT_RANGE;
        for (int i = 0; i + 1 < count; i++) begin
          if (x >= xs[i] && x < xs[i+1]) begin
            t = x;
            t = t - xs[i];
            c2 = qc[i];
            c3 = cc[i];
            d = ds[i];
            h = clamp(c2 + fmul(c3, t), 48);
            h = clamp(d + fmul(h, t), 48);
            r.val = clamp(128'(ys[i]) + fmul(h, t), 32);
            h = clamp(2 * c2 + fmul(3 * c3, t), 48);
            r.slp = clamp(d + fmul(h, t), 32);
            r.crv = clamp(2 * c2 + fmul(6 * c3, t), 32);
            r.st = STAT_EVAL;
            break;
          end
        end
      end
      expected_q = {expected_q, r};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %h expected %h", checked, what, got, want);
      errors++;
    endtask

    task check_result(spline_result_t g);
      spline_result_t e;
      if (expected_q.size() == 0) begin
        report("beat with nothing outstanding", 32'(g.st), '0);
        return;
      end
      e = expected_q.pop_front();
      if (g.val !== e.val) report("value", g.val, e.val);
      if (g.slp !== e.slp) report("slope", g.slp, e.slp);
      if (g.crv !== e.crv) report("curvature", g.crv, e.crv);
      if (g.st !== e.st) report("status", 32'(g.st), 32'(e.st));
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FN_EVAL;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] knot_y = '0;
  logic signed [31:0] knot_slope = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] value, slope, curvature;
  logic [2:0] status;

  spline_scoreboard sb = new();
  bit in_burst, out_burst;
  bit stim_done;
  int idle_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hermite_spline_knot_table u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .pos_x(pos_x), .knot_y(knot_y), .knot_slope(knot_slope),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .slope(slope), .curvature(curvature), .status(status)
  );

  task automatic send_beat(logic f, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] s);
    int gap;
    if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    pos_x = x;
    knot_y = y;
    knot_slope = s;
    do @(posedge clk); while (in_stall);
    sb.note_input(f, x, y, s);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_val();
    return $signed($urandom) >>> $urandom_range(0, 20);
  endfunction

  task automatic random_beat();
    int r, k;
    logic signed [31:0] x;
    r = $urandom_range(0, 99);
    k = sb.count > 0 ? $urandom_range(0, sb.count - 1) : 0;
    if (r < 30) begin
      if (sb.count == 0 || r < 14) x = $urandom;
      else if (r < 27) x = sb.xs[k] + $signed($urandom_range(0, 2000)) - 1000;
      else x = sb.xs[k];
      send_beat(FN_INSERT, x, rand_val(), rand_val());
    end else begin
      if (sb.count == 0 || r < 45) x = $urandom;
      else if (r < 90) x = sb.xs[k] + $urandom_range(0, 1 << $urandom_range(0, 28));
      else x = sb.xs[k];
      send_beat(FN_EVAL, x, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // empty and single-knot tables, extremes of x, last knot, duplicate, tiny dx
    send_beat(FN_EVAL, 0, 32'h7fffffff, 32'h80000000);
    send_beat(FN_INSERT, 0, 32'h7fffffff, 32'h80000000);
    send_beat(FN_EVAL, 0, 0, 0);
    send_beat(FN_INSERT, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_beat(FN_EVAL, 0, 0, 0);
    send_beat(FN_EVAL, 32'h7ffffffe, 0, 0);
    send_beat(FN_EVAL, 32'h7fffffff, 0, 0);
    send_beat(FN_EVAL, 32'h80000000, 0, 0);
    send_beat(FN_INSERT, 0, 5, 5);
    send_beat(FN_INSERT, 32'h80000000, 0, 0);
    send_beat(FN_EVAL, 32'h80000000, 0, 0);
    send_beat(FN_EVAL, -1, 0, 0);
    send_beat(FN_INSERT, 1, -1, 32'h7fffffff);
    send_beat(FN_EVAL, 0, 0, 0);
    send_beat(FN_INSERT, 32'h000a0000, 32'h00030000, 32'hffff0000);
    send_beat(FN_EVAL, 32'h00050000, 0, 0);
    send_beat(FN_EVAL, 32'h00098000, 0, 0);
    send_beat(FN_EVAL, 32'h40000000, 0, 0);
    for (int n = 0; n < N_RANDOM; n++) random_beat();
    in_valid = 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    spline_result_t g;
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 16);
      // one long hold so the block backs up and stalls its input
      if (sb.checked == 200) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      g.val = value;
      g.slp = slope;
      g.crv = curvature;
      g.st = status;
      sb.check_result(g);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    @(posedge clk);
    while (!stim_done || sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
